FILE: hw/rtl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants for the priority voice allocator
// Holds the command codes, the slot record layout and the reset values of
// the per-slot storage.
// ----------------------------------------------------------------------------
package pva_pkg;

    // Default number of voice slots.
    localparam int VOICES_DEF = 32;

    // Reset value of the voice count register.
    localparam logic [5:0] VC_RESET = 6'd32;

    // Reset contents of a slot record.
    localparam logic [7:0]  PRIO_RESET = 8'd128;
    localparam logic [14:0] VOL_RESET  = 15'd256;
    localparam logic [31:0] GEN_RESET  = 32'd1;

    // Request commands; code 7 is unused and ignored.
    typedef enum logic [2:0] {
        CMD_PLAY   = 3'd0,
        CMD_STOP   = 3'd1,
        CMD_PAUSE  = 3'd2,
        CMD_RESUME = 3'd3,
        CMD_SETVOL = 3'd4,
        CMD_QUERY  = 3'd5,
        CMD_ENDED  = 3'd6
    } t_cmd;

    // Per-slot record kept in the slot memory.
    typedef struct packed {
        logic [7:0]  prio;
        logic [14:0] vol;
        logic [31:0] gen;
    } t_slot_rec;

    localparam t_slot_rec REC_RESET = '{prio: PRIO_RESET, vol: VOL_RESET, gen: GEN_RESET};

    // Outcome flags of a slot scan.
    typedef struct packed {
        logic free_found;
        logic vict_found;
    } t_scan_flags;

endpackage

FILE: hw/rtl/pva_slot_mem.sv
// ----------------------------------------------------------------------------
// pva_slot_mem: slot record memory
// One write port and one registered read port. Entries never written since
// reset read back as the reset record, tracked by one init bit per slot.
// ----------------------------------------------------------------------------
module pva_slot_mem #(
    parameter int VOICES = pva_pkg::VOICES_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_rd_en,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] i_rd_addr,
    output pva_pkg::t_slot_rec                           o_rd_rec,
    input  logic                                         i_wr_en,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] i_wr_addr,
    input  pva_pkg::t_slot_rec                           i_wr_rec
);

    pva_pkg::t_slot_rec r_mem [VOICES];
    pva_pkg::t_slot_rec r_rd_data;
    logic [VOICES-1:0]  r_init;
    logic               r_rd_init;

    // Memory array: write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_rec;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_init <= r_init[i_rd_addr];
        end
    end

    // Init bits mark entries that hold written data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (i_wr_en) begin
            r_init[i_wr_addr] <= 1'b1;
        end
    end

    // An entry never written reads as the reset record.
    assign o_rd_rec = r_rd_init ? r_rd_data : pva_pkg::REC_RESET;

endmodule

FILE: hw/rtl/pva_scan.sv
// ----------------------------------------------------------------------------
// pva_scan: serial slot scan unit
// Takes one slot per cycle while i_valid is high and tracks the lowest free slot, the best steal
// victim and the number of busy slots seen.
// ----------------------------------------------------------------------------
module pva_scan #(
    parameter int VOICES = pva_pkg::VOICES_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_clear,
    input  logic                                           i_valid,
    input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0]   i_idx,
    input  logic                                           i_busy,
    input  pva_pkg::t_slot_rec                             i_rec,
    input  logic [7:0]                                     i_req_prio,
    output pva_pkg::t_scan_flags                           o_flags,
    output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0]   o_free_idx,
    output logic [31:0]                                    o_free_gen,
    output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0]   o_vict_idx,
    output pva_pkg::t_slot_rec                             o_vict_rec,
    output logic [$clog2(VOICES + 1)-1:0]                  o_count
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);

    pva_pkg::t_scan_flags r_flags;
    logic [IW-1:0]        r_free_idx;
    logic [31:0]          r_free_gen;
    logic [IW-1:0]        r_vict_idx;
    pva_pkg::t_slot_rec   r_vict_rec;
    logic [CW-1:0]        r_count;
    logic                 better;

    // Victim compare: priority at least the request's, then larger
    // priority, then lower volume; earlier slots win exact ties.
    always_comb begin
        better = (i_rec.prio >= i_req_prio) &&
                 (!r_flags.vict_found || (i_rec.prio > r_vict_rec.prio) ||
                  ((i_rec.prio == r_vict_rec.prio) && (i_rec.vol < r_vict_rec.vol)));
    end

    // Control state of the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_flags <= '0;
            r_count <= '0;
        end else if (i_valid) begin
            if (i_busy) begin
                r_count <= r_count + CW'(1);
            end
            if (!i_busy) begin
                r_flags.free_found <= 1'b1;
            end
            if (better) begin
                r_flags.vict_found <= 1'b1;
            end
        end
    end

    // Captured slot data.
    always_ff @(posedge i_clk) begin
        if (i_valid && !i_busy && !r_flags.free_found) begin
            r_free_idx <= i_idx;
            r_free_gen <= i_rec.gen;
        end
        if (i_valid && better) begin
            r_vict_idx <= i_idx;
            r_vict_rec <= i_rec;
        end
    end

    assign o_flags    = r_flags;
    assign o_free_idx = r_free_idx;
    assign o_free_gen = r_free_gen;
    assign o_vict_idx = r_vict_idx;
    assign o_vict_rec = r_vict_rec;
    assign o_count    = r_count;

endmodule

FILE: hw/rtl/priority_voice_allocator.sv
// A request is served by a serial scan over the first n slots, where n is the
// live voice count (voice_count clamped to 1..VOICES), through the slot memory's
// single read port; no new request is accepted until the result has been taken.
// Reset (synchronous, active low) frees all slots, returns every record to its
// reset value through init bits at once, and sets voice_count to 32.
// ----------------------------------------------------------------------------
// priority_voice_allocator: voice slot allocator with generation handles
// Play takes the lowest free slot or steals the least important voice; Ended acts
// on a slot by index alone; the other commands act through index and generation.
// ----------------------------------------------------------------------------
module priority_voice_allocator #(
    parameter int VOICES = pva_pkg::VOICES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_cmd,
    input  logic [4:0]         i_slot_index,
    input  logic [31:0]        i_handle_generation,
    input  logic [7:0]         i_request_priority,
    input  logic signed [15:0] i_request_volume,
    input  logic               i_request_loop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_ok,
    output logic [4:0]         o_out_index,
    output logic [31:0]        o_out_generation,
    output logic               o_stole,
    output logic               o_is_playing,
    output logic [5:0]         o_active_voices,
    output logic [31:0]        o_steals_total
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_OUT    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration and slot status flops.
    logic [5:0]        r_voice_count;
    logic [VOICES-1:0] r_busy;
    logic [VOICES-1:0] r_paused;
    logic [VOICES-1:0] r_looping;
    logic [31:0]       r_steals;

    // Latched request.
    pva_pkg::t_cmd r_cmd;
    logic [4:0]    r_hidx;
    logic [31:0]   r_hgen;
    logic [7:0]    r_prio;
    logic [14:0]   r_vol;
    logic          r_loop;
    logic [CW-1:0] r_n;
    logic [CW-1:0] n_n;

    // Scan pipeline.
    logic [IW-1:0]      r_addr;
    logic               r_rd_vld;
    logic [IW-1:0]      r_rd_idx;
    pva_pkg::t_slot_rec rd_rec;
    pva_pkg::t_slot_rec r_h_rec;
    logic               accept;
    logic               rd_en;
    logic [IW-1:0]      hslot;

    // Scan results.
    pva_pkg::t_scan_flags scan_flags;
    logic [IW-1:0]        scan_free_idx;
    logic [31:0]          scan_free_gen;
    logic [IW-1:0]        scan_vict_idx;
    pva_pkg::t_slot_rec   scan_vict_rec;
    logic [CW-1:0]        scan_count;

    // Finish step decisions.
    logic               inrange;
    logic               resolved;
    logic [IW-1:0]      fin_slot;
    logic               fin_wr;
    pva_pkg::t_slot_rec fin_rec;
    logic               fin_take;
    logic               fin_free;
    logic               fin_pause;
    logic               fin_resume;
    logic               fin_steal;

    // Result register.
    logic          r_o_ok;
    logic [4:0]    r_o_idx;
    logic [31:0]   r_o_gen;
    logic          r_o_stole;
    logic          r_o_playing;
    logic [CW-1:0] r_o_active;
    logic          n_o_ok;
    logic [4:0]    n_o_idx;
    logic [31:0]   n_o_gen;
    logic          n_o_stole;
    logic          n_o_playing;
    logic [CW-1:0] n_o_active;

    assign accept = (r_state == ST_IDLE) && i_in_valid;
    assign rd_en  = (r_state == ST_SCAN);
    assign hslot  = IW'(r_hidx);

    // Live count: zero acts as one, values above VOICES act as VOICES.
    always_comb begin
        if (r_voice_count == 6'd0) begin
            n_n = CW'(1);
        end else if (32'(r_voice_count) > VOICES) begin
            n_n = CW'(VOICES);
        end else begin
            n_n = CW'(r_voice_count);
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == IW'(r_n - CW'(1))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_FINISH;
            ST_FINISH: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_voice_count <= pva_pkg::VC_RESET;
            r_rd_vld      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (i_cfg_we) begin
                r_voice_count <= i_cfg_data;
            end
        end
    end

    // Request latch, scan address and handle slot capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= pva_pkg::t_cmd'(i_cmd);
            r_hidx <= i_slot_index;
            r_hgen <= i_handle_generation;
            r_prio <= i_request_priority;
            r_vol  <= i_request_volume[15] ? 15'd0 : i_request_volume[14:0];
            r_loop <= i_request_loop;
            r_n    <= n_n;
            r_addr <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + IW'(1);
        end
        if (rd_en) begin
            r_rd_idx <= r_addr;
        end
        if (r_rd_vld && (r_rd_idx == hslot)) begin
            r_h_rec <= rd_rec;
        end
    end

    pva_slot_mem #(
        .VOICES (VOICES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_rec  (rd_rec),
        .i_wr_en   (fin_wr),
        .i_wr_addr (fin_slot),
        .i_wr_rec  (fin_rec)
    );

    pva_scan #(
        .VOICES (VOICES)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (accept),
        .i_valid    (r_rd_vld),
        .i_idx      (r_rd_idx),
        .i_busy     (r_busy[r_rd_idx]),
        .i_rec      (rd_rec),
        .i_req_prio (r_prio),
        .o_flags    (scan_flags),
        .o_free_idx (scan_free_idx),
        .o_free_gen (scan_free_gen),
        .o_vict_idx (scan_vict_idx),
        .o_vict_rec (scan_vict_rec),
        .o_count    (scan_count)
    );

    // Finish step: decide the slot update and the result.
    always_comb begin
        inrange  = (32'(r_hidx) < 32'(r_n));
        resolved = inrange && r_busy[hslot] && (r_h_rec.gen == r_hgen);

        fin_slot    = hslot;
        fin_wr      = 1'b0;
        fin_rec     = r_h_rec;
        fin_take    = 1'b0;
        fin_free    = 1'b0;
        fin_pause   = 1'b0;
        fin_resume  = 1'b0;
        fin_steal   = 1'b0;
        n_o_ok      = 1'b0;
        n_o_idx     = 5'd0;
        n_o_gen     = 32'd0;
        n_o_stole   = 1'b0;
        n_o_playing = 1'b0;
        n_o_active  = scan_count;

        unique case (r_cmd)
            pva_pkg::CMD_PLAY: begin
                if (scan_flags.free_found) begin
                    fin_slot   = scan_free_idx;
                    fin_rec    = '{prio: r_prio, vol: r_vol, gen: scan_free_gen};
                    fin_wr     = 1'b1;
                    fin_take   = 1'b1;
                    n_o_ok     = 1'b1;
                    n_o_idx    = 5'(scan_free_idx);
                    n_o_gen    = scan_free_gen;
                    n_o_active = scan_count + CW'(1);
                end else if (scan_flags.vict_found) begin
                    fin_slot  = scan_vict_idx;
                    fin_rec   = '{prio: r_prio, vol: r_vol,
                                  gen: scan_vict_rec.gen + 32'd1};
                    fin_wr    = 1'b1;
                    fin_take  = 1'b1;
                    fin_steal = 1'b1;
                    n_o_ok    = 1'b1;
                    n_o_stole = 1'b1;
                    n_o_idx   = 5'(scan_vict_idx);
                    n_o_gen   = scan_vict_rec.gen + 32'd1;
                end
            end
            pva_pkg::CMD_STOP: begin
                if (resolved) begin
                    fin_rec.gen = r_h_rec.gen + 32'd1;
                    fin_wr      = 1'b1;
                    fin_free    = 1'b1;
                    n_o_ok      = 1'b1;
                    n_o_active  = scan_count - CW'(1);
                end
            end
            pva_pkg::CMD_PAUSE: begin
                fin_pause = resolved;
                n_o_ok    = resolved;
            end
            pva_pkg::CMD_RESUME: begin
                fin_resume = resolved;
                n_o_ok     = resolved;
            end
            pva_pkg::CMD_SETVOL: begin
                if (resolved) begin
                    fin_rec.vol = r_vol;
                    fin_wr      = 1'b1;
                    n_o_ok      = 1'b1;
                end
            end
            pva_pkg::CMD_QUERY: begin
                n_o_ok      = resolved;
                n_o_playing = resolved && !r_paused[hslot];
            end
            pva_pkg::CMD_ENDED: begin
                if (inrange && r_busy[hslot] && !r_looping[hslot]) begin
                    fin_rec.gen = r_h_rec.gen + 32'd1;
                    fin_wr      = 1'b1;
                    fin_free    = 1'b1;
                    n_o_ok      = 1'b1;
                    n_o_active  = scan_count - CW'(1);
                end
            end
            default: begin
                n_o_ok = 1'b0;
            end
        endcase

        if (r_state != ST_FINISH) begin
            fin_wr = 1'b0;
        end
    end

    // Slot status flops and the steal counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_paused  <= '0;
            r_looping <= '0;
            r_steals  <= 32'd0;
        end else if (r_state == ST_FINISH) begin
            if (fin_take) begin
                r_busy[fin_slot]    <= 1'b1;
                r_paused[fin_slot]  <= 1'b0;
                r_looping[fin_slot] <= r_loop;
            end
            if (fin_free) begin
                r_busy[fin_slot]   <= 1'b0;
                r_paused[fin_slot] <= 1'b0;
            end
            if (fin_pause) begin
                r_paused[fin_slot] <= 1'b1;
            end
            if (fin_resume) begin
                r_paused[fin_slot] <= 1'b0;
            end
            if (fin_steal) begin
                r_steals <= r_steals + 32'd1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH) begin
            r_o_ok      <= n_o_ok;
            r_o_idx     <= n_o_idx;
            r_o_gen     <= n_o_gen;
            r_o_stole   <= n_o_stole;
            r_o_playing <= n_o_playing;
            r_o_active  <= n_o_active;
        end
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = (r_state == ST_OUT);
    assign o_ok             = r_o_ok;
    assign o_out_index      = r_o_idx;
    assign o_out_generation = r_o_gen;
    assign o_stole          = r_o_stole;
    assign o_is_playing     = r_o_playing;
    assign o_active_voices  = 6'(r_o_active);
    assign o_steals_total   = r_steals;

`ifndef SYNTHESIS
    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("Sequencer state is not one-hot.");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("Request channel open while a result is pending.");

    a_steals_only_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_FINISH) |=> $stable(r_steals))
        else $error("Steal counter changed outside the finish step.");

    a_stole_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stole) |-> o_ok)
        else $error("Steal reported on a failed play.");

    a_active_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(r_o_active) <= 32'(r_n)))
        else $error("Active voice count exceeds the live count.");
`endif

endmodule
